@@ sv/sdf_pkg.sv @@
// Shared types, constants and helpers for the spring damper force pipeline.
package sdf_pkg;

  localparam int DATA_W = 32;
  localparam int REST_W = 31;
  localparam int DAMP_W = 17;
  localparam int MASK_W = 16;

  // Magnitude bound applied to intermediate products (2^60).
  localparam logic [63:0] SM_CAP = 64'h1000_0000_0000_0000;

  // Per-spring payload carried alongside the arithmetic stages.
  typedef struct packed {
    logic [2:0][DATA_W-1:0] d;
    logic [2:0][DATA_W-1:0] v;
    logic [REST_W-1:0]      rest;
    logic [REST_W-1:0]      stiff;
    logic [DAMP_W-1:0]      damp;
    logic                   skip;
  } sdf_side_t;

  // Absolute value of a two's complement word, returned unsigned.
  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? DATA_W'(-x) : x;
  endfunction

endpackage

@@ sv/spring_damper_force.sv @@
// Pipelined force evaluation for one mass-spring-damper link per transaction.
//
// Usage: each input transaction describes one spring (position and velocity
// differences of its two bodies, rest length, stiffness, damping, group masks).
// Each one yields exactly one output transaction with the force vector and the
// skipped, degenerate and saturated flags, in input order.
// Throughput: one transaction per cycle unless the receiver stalls. Depth: FRAC_BITS + 79
// register stages, set by three entry stages, the one-bit-per-stage square root
// (32 stages), the one-bit-per-stage dividers (FRAC_BITS + 33 stages including
// their entry) and eleven multiply, sum and saturate stages.
// The group mask register is written through cfg_wr_en / cfg_wr_data and is
// sampled as each transaction enters; write it only while the pipe is empty.
// Reset (rst_n low, synchronous) empties the pipeline and sets the group mask
// to all ones. When the receiver stalls a valid result, the whole pipeline
// holds and in_stall rises; nothing is dropped or repeated.
module spring_damper_force
  import sdf_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int MASK_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_delta_x,
  input  logic signed [DATA_W-1:0] in_delta_y,
  input  logic signed [DATA_W-1:0] in_delta_z,
  input  logic signed [DATA_W-1:0] in_rel_vel_x,
  input  logic signed [DATA_W-1:0] in_rel_vel_y,
  input  logic signed [DATA_W-1:0] in_rel_vel_z,
  input  logic [REST_W-1:0]        in_rest_length,
  input  logic [REST_W-1:0]        in_stiffness,
  input  logic [DAMP_W-1:0]        in_damping,
  input  logic [MASK_W-1:0]        in_mask_first,
  input  logic [MASK_W-1:0]        in_mask_second,
  input  logic                     cfg_wr_en,
  input  logic [MASK_W-1:0]        cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_force_x,
  output logic signed [DATA_W-1:0] out_force_y,
  output logic signed [DATA_W-1:0] out_force_z,
  output logic                     out_skipped,
  output logic                     out_degenerate,
  output logic                     out_saturated
);

  localparam int SQ_STEPS = 32;
  localparam int NUM_W    = 32 + FRAC_BITS;
  localparam int DM_W     = FRAC_BITS + 1;
  localparam int DIR_W    = FRAC_BITS + 2;
  localparam int EHI_W    = NUM_W - 32;
  localparam int T1P_W    = NUM_W + 31;
  localparam int DOT_W    = DIR_W + 34;
  localparam int RVM_W    = 33;
  localparam int OD_W     = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
  localparam int ODM_W    = OD_W - 1;
  localparam int T2P_W    = RVM_W + ODM_W;
  localparam int S_W      = 62;
  localparam int SM_W     = 61;
  localparam int FP_W     = SM_W + DM_W;
  localparam int POST     = 10;
  localparam logic [MASK_W-1:0] MASK_ALL =
    (MASK_BITS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << MASK_BITS) - 64'd1);
  localparam logic signed [S_W:0] CAP_S = (S_W+1)'(SM_CAP);

  logic pipe_adv;
  logic [MASK_W-1:0] group_mask_r;

  // Whole pipeline advances unless a finished result is held by the receiver.
  assign pipe_adv = !(out_valid && out_stall);
  assign in_stall = !pipe_adv;

  // Group mask register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_mask_r <= {MASK_W{1'b1}};
    end else if (cfg_wr_en) begin
      group_mask_r <= cfg_wr_data;
    end
  end

  // Stage s0: capture the transaction and decide the group test.
  logic      s0_vld_r;
  sdf_side_t s0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (pipe_adv) begin
      s0_vld_r <= in_valid;
    end
    if (pipe_adv) begin
      s0_side_r.d     <= {in_delta_z, in_delta_y, in_delta_x};
      s0_side_r.v     <= {in_rel_vel_z, in_rel_vel_y, in_rel_vel_x};
      s0_side_r.rest  <= in_rest_length;
      s0_side_r.stiff <= in_stiffness;
      s0_side_r.damp  <= in_damping;
      s0_side_r.skip  <= ((in_mask_first & in_mask_second & group_mask_r & MASK_ALL) == '0);
    end
  end

  // Stage s1: squares of the position difference components.
  logic      s1_vld_r;
  sdf_side_t s1_side_r;
  logic [63:0] s1_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (pipe_adv) begin
      s1_vld_r <= s0_vld_r;
    end
    if (pipe_adv) begin
      s1_side_r <= s0_side_r;
      for (int i = 0; i < 3; i++) begin
        s1_sq_r[i] <= 64'(mag32(s0_side_r.d[i])) * 64'(mag32(s0_side_r.d[i]));
      end
    end
  end

  // Square root pipeline; entry 0 holds the sum of squares.
  logic        sq_vld_r  [0:SQ_STEPS];
  sdf_side_t   sq_side_r [0:SQ_STEPS];
  logic [63:0] sq_rad_r  [0:SQ_STEPS];
  logic [32:0] sq_rem_r  [0:SQ_STEPS];
  logic [31:0] sq_root_r [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (pipe_adv) begin
      sq_vld_r[0] <= s1_vld_r;
    end
    if (pipe_adv) begin
      sq_side_r[0] <= s1_side_r;
      sq_rad_r[0]  <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [34:0] rtmp;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;
    logic [32:0] rem_nxt;
    logic [31:0] root_nxt;

    // One root bit per stage: try subtracting 4*root+1 from the running remainder.
    always_comb begin
      rtmp     = {sq_rem_r[k], sq_rad_r[k][63:62]};
      trial    = {1'b0, sq_root_r[k], 2'b01};
      diff     = rtmp - trial;
      ge       = (rtmp >= trial);
      rem_nxt  = ge ? diff[32:0] : rtmp[32:0];
      root_nxt = {sq_root_r[k][30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (pipe_adv) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
      if (pipe_adv) begin
        sq_side_r[k+1] <= sq_side_r[k];
        sq_rad_r[k+1]  <= {sq_rad_r[k][61:0], 2'b00};
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= root_nxt;
      end
    end
  end

  // Divider pipeline: lanes 0..2 give the direction d_i*2^F/L, lane 3 the strain.
  logic             dv_vld_r   [0:NUM_W];
  sdf_side_t        dv_side_r  [0:NUM_W];
  logic             dv_degen_r [0:NUM_W];
  logic [2:0]       dv_dneg_r  [0:NUM_W];
  logic             dv_eneg_r  [0:NUM_W];
  logic [31:0]      dv_len_r   [0:NUM_W];
  logic [31:0]      dv_rem_r   [0:NUM_W][4];
  logic [NUM_W-1:0] dv_num_r   [0:NUM_W][4];

  logic [31:0] ent_len;
  logic [31:0] ent_rest;
  logic        ent_eneg;
  logic [31:0] ent_emag;

  always_comb begin
    ent_len  = sq_root_r[SQ_STEPS];
    ent_rest = 32'(sq_side_r[SQ_STEPS].rest);
    ent_eneg = (ent_len < ent_rest);
    ent_emag = ent_eneg ? (ent_rest - ent_len) : (ent_len - ent_rest);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (pipe_adv) begin
      dv_vld_r[0] <= sq_vld_r[SQ_STEPS];
    end
    if (pipe_adv) begin
      dv_side_r[0]  <= sq_side_r[SQ_STEPS];
      dv_degen_r[0] <= (ent_len == '0) || (ent_rest == '0);
      dv_eneg_r[0]  <= ent_eneg;
      dv_len_r[0]   <= ent_len;
      for (int i = 0; i < 3; i++) begin
        dv_dneg_r[0][i] <= sq_side_r[SQ_STEPS].d[i][DATA_W-1];
        dv_rem_r[0][i]  <= '0;
        dv_num_r[0][i]  <= {mag32(sq_side_r[SQ_STEPS].d[i]), {FRAC_BITS{1'b0}}};
      end
      dv_rem_r[0][3] <= '0;
      dv_num_r[0][3] <= {ent_emag, {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    logic [31:0]      den      [4];
    logic [32:0]      rtmp     [4];
    logic [32:0]      diff     [4];
    logic [3:0]       ge;
    logic [31:0]      rem_nxt  [4];
    logic [NUM_W-1:0] num_nxt  [4];

    // Restoring division, one quotient bit per lane and stage.
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        den[l]     = (l == 3) ? 32'(dv_side_r[j].rest) : dv_len_r[j];
        rtmp[l]    = {dv_rem_r[j][l], dv_num_r[j][l][NUM_W-1]};
        diff[l]    = rtmp[l] - {1'b0, den[l]};
        ge[l]      = (rtmp[l] >= {1'b0, den[l]});
        rem_nxt[l] = ge[l] ? diff[l][31:0] : rtmp[l][31:0];
        num_nxt[l] = {dv_num_r[j][l][NUM_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (pipe_adv) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
      if (pipe_adv) begin
        dv_side_r[j+1]  <= dv_side_r[j];
        dv_degen_r[j+1] <= dv_degen_r[j];
        dv_dneg_r[j+1]  <= dv_dneg_r[j];
        dv_eneg_r[j+1]  <= dv_eneg_r[j];
        dv_len_r[j+1]   <= dv_len_r[j];
        for (int l = 0; l < 4; l++) begin
          dv_rem_r[j+1][l] <= rem_nxt[l];
          dv_num_r[j+1][l] <= num_nxt[l];
        end
      end
    end
  end

  // Post-division carry chain: payload, flags and direction for stages p0..p9.
  logic            pc_vld_r   [0:POST];
  sdf_side_t       pc_side_r  [0:POST-1];
  logic            pc_degen_r [0:POST-1];
  logic [DM_W-1:0] pc_dm_r    [0:POST-1][3];
  logic [2:0]      pc_dneg_r  [0:POST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_vld_r[0] <= 1'b0;
    end else if (pipe_adv) begin
      pc_vld_r[0] <= dv_vld_r[NUM_W];
    end
    if (pipe_adv) begin
      pc_side_r[0]  <= dv_side_r[NUM_W];
      pc_degen_r[0] <= dv_degen_r[NUM_W];
      pc_dneg_r[0]  <= dv_dneg_r[NUM_W];
      for (int i = 0; i < 3; i++) begin
        pc_dm_r[0][i] <= dv_num_r[NUM_W][i][DM_W-1:0];
      end
    end
  end

  for (genvar j = 1; j <= POST; j++) begin : g_carry
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pc_vld_r[j] <= 1'b0;
      end else if (pipe_adv) begin
        pc_vld_r[j] <= pc_vld_r[j-1];
      end
    end
    if (j < POST) begin : g_pay
      always_ff @(posedge clk) begin
        if (pipe_adv) begin
          pc_side_r[j]  <= pc_side_r[j-1];
          pc_degen_r[j] <= pc_degen_r[j-1];
          pc_dneg_r[j]  <= pc_dneg_r[j-1];
          pc_dm_r[j]    <= pc_dm_r[j-1];
        end
      end
    end
  end

  // p0: signed direction and strain magnitude.
  logic signed [DIR_W-1:0] p0_dir_r [3];
  logic [NUM_W-1:0]        p0_emag_r;
  logic                    p0_eneg_r;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      for (int i = 0; i < 3; i++) begin
        p0_dir_r[i] <= dv_dneg_r[NUM_W][i] ? -$signed({1'b0, dv_num_r[NUM_W][i][DM_W-1:0]})
                                           : $signed({1'b0, dv_num_r[NUM_W][i][DM_W-1:0]});
      end
      p0_emag_r <= dv_num_r[NUM_W][3];
      p0_eneg_r <= dv_eneg_r[NUM_W];
    end
  end

  // p1: direction times velocity, strain times stiffness in two partial products.
  logic signed [DIR_W+31:0] p1_dot_r [3];
  logic [62:0]              p1_t1lo_r;
  logic [EHI_W+30:0]        p1_t1hi_r;
  logic                     p1_eneg_r;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_dot_r[i] <= p0_dir_r[i] * $signed(pc_side_r[0].v[i]);
      end
      p1_t1lo_r <= 63'(p0_emag_r[31:0]) * 63'(pc_side_r[0].stiff);
      p1_t1hi_r <= (EHI_W+31)'(p0_emag_r[NUM_W-1:32]) * (EHI_W+31)'(pc_side_r[0].stiff);
      p1_eneg_r <= p0_eneg_r;
    end
  end

  // p2: dot product sum and full strain-stiffness product.
  logic signed [DOT_W-1:0] p2_dot_r;
  logic [T1P_W-1:0]        p2_t1p_r;
  logic                    p2_eneg_r;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      p2_dot_r  <= DOT_W'(p1_dot_r[0]) + DOT_W'(p1_dot_r[1]) + DOT_W'(p1_dot_r[2]);
      p2_t1p_r  <= (T1P_W'(p1_t1hi_r) << 32) + T1P_W'(p1_t1lo_r);
      p2_eneg_r <= p1_eneg_r;
    end
  end

  // p3: relative velocity, capped elastic term, and 1 - damping.
  logic [DOT_W-1:0] p3_dot_mag;
  logic             p3_t1_ovf;
  logic [63:0]      p3_t1_m;
  logic [63:0]      p3_t1_mc;
  logic [ODM_W-1:0] p3_one;
  logic [ODM_W-1:0] p3_damp;

  logic [RVM_W-1:0]      p3_rvmag_r;
  logic                  p3_rvneg_r;
  logic signed [S_W-1:0] p3_t1_r;
  logic [ODM_W-1:0]      p3_odmag_r;
  logic                  p3_odneg_r;

  always_comb begin
    p3_dot_mag = p2_dot_r[DOT_W-1] ? DOT_W'(-p2_dot_r) : DOT_W'(p2_dot_r);
    p3_t1_ovf  = |p2_t1p_r[T1P_W-1:64];
    p3_t1_m    = 64'(p2_t1p_r[63:FRAC_BITS]);
    p3_t1_mc   = (p3_t1_ovf || (p3_t1_m > SM_CAP)) ? SM_CAP : p3_t1_m;
    p3_one     = ODM_W'(1) << FRAC_BITS;
    p3_damp    = ODM_W'(pc_side_r[2].damp);
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      p3_rvmag_r <= p3_dot_mag[FRAC_BITS +: RVM_W];
      p3_rvneg_r <= p2_dot_r[DOT_W-1];
      p3_t1_r    <= p2_eneg_r ? -$signed(S_W'(p3_t1_mc)) : $signed(S_W'(p3_t1_mc));
      p3_odneg_r <= (p3_damp > p3_one);
      p3_odmag_r <= (p3_damp > p3_one) ? (p3_damp - p3_one) : (p3_one - p3_damp);
    end
  end

  // p4: damping product.
  logic [T2P_W-1:0]      p4_t2p_r;
  logic                  p4_t2neg_r;
  logic signed [S_W-1:0] p4_t1_r;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      p4_t2p_r   <= T2P_W'(p3_rvmag_r) * T2P_W'(p3_odmag_r);
      p4_t2neg_r <= p3_rvneg_r ^ p3_odneg_r;
      p4_t1_r    <= p3_t1_r;
    end
  end

  // p5: rescale and sign the damping term.
  logic [S_W-1:0]        p5_t2m;
  logic signed [S_W-1:0] p5_t2_r;
  logic signed [S_W-1:0] p5_t1_r;

  assign p5_t2m = S_W'(p4_t2p_r[T2P_W-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      p5_t2_r <= p4_t2neg_r ? -$signed(p5_t2m) : $signed(p5_t2m);
      p5_t1_r <= p4_t1_r;
    end
  end

  // p6: scalar force, clamped to the magnitude bound.
  logic signed [S_W:0]   p6_sum;
  logic signed [S_W-1:0] p6_s_r;

  assign p6_sum = (S_W+1)'(p5_t1_r) + (S_W+1)'(p5_t2_r);

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      priority if (p6_sum > CAP_S) begin
        p6_s_r <= S_W'(CAP_S);
      end else if (p6_sum < -CAP_S) begin
        p6_s_r <= S_W'(-CAP_S);
      end else begin
        p6_s_r <= S_W'(p6_sum);
      end
    end
  end

  // p7: magnitude and sign of the scalar force.
  logic [SM_W-1:0] p7_smag_r;
  logic            p7_sneg_r;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      p7_smag_r <= p6_s_r[S_W-1] ? SM_W'(-p6_s_r) : SM_W'(p6_s_r);
      p7_sneg_r <= p6_s_r[S_W-1];
    end
  end

  // p8: scalar force times direction, split into two partial products.
  logic [31+DM_W:0]      p8_lo_r [3];
  logic [SM_W-33+DM_W:0] p8_hi_r [3];
  logic [2:0]            p8_fneg_r;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      for (int i = 0; i < 3; i++) begin
        p8_lo_r[i]   <= (32+DM_W)'(p7_smag_r[31:0]) * (32+DM_W)'(pc_dm_r[7][i]);
        p8_hi_r[i]   <= (SM_W-32+DM_W)'(p7_smag_r[SM_W-1:32]) * (SM_W-32+DM_W)'(pc_dm_r[7][i]);
        p8_fneg_r[i] <= p7_sneg_r ^ pc_dneg_r[7][i];
      end
    end
  end

  // p9: assemble the component products.
  logic [FP_W-1:0] p9_fp_r [3];
  logic [2:0]      p9_fneg_r;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      for (int i = 0; i < 3; i++) begin
        p9_fp_r[i] <= (FP_W'(p8_hi_r[i]) << 32) + FP_W'(p8_lo_r[i]);
      end
      p9_fneg_r <= p8_fneg_r;
    end
  end

  // p10: rescale, saturate to 32 bits and apply the flags; this is the output register.
  logic [63:0]       fin_m   [3];
  logic [2:0]        fin_sat;
  logic [DATA_W-1:0] fin_val [3];
  logic              fin_zero;

  logic [DATA_W-1:0] out_force_r [3];
  logic              out_skip_r;
  logic              out_degen_r;
  logic              out_sat_r;

  always_comb begin
    fin_zero = pc_side_r[9].skip || pc_degen_r[9];
    for (int i = 0; i < 3; i++) begin
      fin_m[i] = 64'(p9_fp_r[i][63:FRAC_BITS]);
      if (p9_fneg_r[i]) begin
        fin_sat[i] = (|p9_fp_r[i][FP_W-1:64]) || (fin_m[i] > 64'h8000_0000);
        fin_val[i] = fin_sat[i] ? 32'h8000_0000 : DATA_W'(-fin_m[i]);
      end else begin
        fin_sat[i] = (|p9_fp_r[i][FP_W-1:64]) || (fin_m[i] > 64'h7FFF_FFFF);
        fin_val[i] = fin_sat[i] ? 32'h7FFF_FFFF : fin_m[i][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      for (int i = 0; i < 3; i++) begin
        out_force_r[i] <= fin_zero ? '0 : fin_val[i];
      end
      out_skip_r  <= pc_side_r[9].skip;
      out_degen_r <= !pc_side_r[9].skip && pc_degen_r[9];
      out_sat_r   <= !fin_zero && (|fin_sat);
    end
  end

  assign out_valid      = pc_vld_r[POST];
  assign out_force_x    = $signed(out_force_r[0]);
  assign out_force_y    = $signed(out_force_r[1]);
  assign out_force_z    = $signed(out_force_r[2]);
  assign out_skipped    = out_skip_r;
  assign out_degenerate = out_degen_r;
  assign out_saturated  = out_sat_r;

  // A flagged transaction never carries a force.
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_skipped || out_degenerate) |->
      (out_force_x == '0) && (out_force_y == '0) && (out_force_z == '0) && !out_saturated)
    else $error("flagged result has nonzero force");

  // Skipped and degenerate exclude each other.
  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_skipped && out_degenerate))
    else $error("skipped and degenerate both set");

  // Saturation leaves at least one component on a rail.
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_force_x == 32'sh7FFF_FFFF) || (out_force_x == -32'sh8000_0000) ||
      (out_force_y == 32'sh7FFF_FFFF) || (out_force_y == -32'sh8000_0000) ||
      (out_force_z == 32'sh7FFF_FFFF) || (out_force_z == -32'sh8000_0000))
    else $error("saturated flag without a clamped component");

  // Direction components never exceed unit length.
  a_dir_unit: assert property (@(posedge clk) disable iff (!rst_n)
    pc_vld_r[0] && !pc_degen_r[0] |->
      (pc_dm_r[0][0] <= (DM_W'(1) << FRAC_BITS)) &&
      (pc_dm_r[0][1] <= (DM_W'(1) << FRAC_BITS)) &&
      (pc_dm_r[0][2] <= (DM_W'(1) << FRAC_BITS)))
    else $error("direction magnitude above one");

  // The group mask comes out of reset with every group enabled.
  a_mask_reset: assert property (@(posedge clk)
    !rst_n |=> (group_mask_r == {MASK_W{1'b1}}))
    else $error("group mask not set by reset");

endmodule
